[sv/mqhd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqhd_pkg
// Shared types, constants and character helpers for the Q-encoded header
// word decoder.
// ----------------------------------------------------------------------------
package mqhd_pkg;

    // Lookahead window and start token
    localparam int LOOKAHEAD_DEPTH = 15;
    localparam int START_LEN       = 15;
    localparam int CNT_W           = $clog2(LOOKAHEAD_DEPTH + 1);

    localparam logic [7:0] START_TOKEN [START_LEN] = '{
        8'h3D, 8'h3F, 8'h49, 8'h53, 8'h4F, 8'h2D, 8'h38, 8'h38,
        8'h35, 8'h39, 8'h2D, 8'h31, 8'h3F, 8'h51, 8'h3F
    };  // "=?ISO-8859-1?Q?"

    // Characters
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_QM    = 8'h3F;  // '?'
    localparam logic [7:0] CH_US    = 8'h5F;  // '_'
    localparam logic [7:0] CH_SP    = 8'h20;  // ' '
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
    localparam logic [7:0] CH_A_OFS = 8'd55;  // 'A' - 10
    localparam logic [7:0] CASE_OFS = 8'd32;

    localparam logic [15:0] MAX_OUT_RESET = 16'hFFFF;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLOSE
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic append;   // store the accepted byte at the window tail
        logic decode;   // decide one action at the window head
        logic close;    // send the end-of-text beat and clear text state
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;     // window holds START_LEN bytes, the length of a start token
        logic nonempty;
        logic out_free; // output register can take a beat this cycle
    } dp_status_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
               (c >= CH_LA && c <= CH_LF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] v;
        u = upcase(c);
        v = (u >= CH_UA) ? u - CH_A_OFS : u - CH_ZERO;
        return v[3:0];
    endfunction

endpackage

[sv/mqhd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqhd_in_if
// Input channel: one header text byte per beat, with a last-byte mark.
// ----------------------------------------------------------------------------
interface mqhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[sv/mqhd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqhd_out_if
// Output channel: one decoded byte or the end-of-text mark per beat.
// ----------------------------------------------------------------------------
interface mqhd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic       truncated;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_text, output truncated, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_text, input truncated, output ready);
endinterface

[sv/mqhd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqhd_ctrl
// Sequencer: accepts a byte, then steps the datapath through head decodes
// and, after the final byte, the closing beat.
// ----------------------------------------------------------------------------
module mqhd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  mqhd_pkg::dp_status_t status,
    output mqhd_pkg::dp_cmd_t    cmd
);

    mqhd_pkg::ctl_state_t state_reg;
    mqhd_pkg::ctl_state_t state_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 need_decode;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mqhd_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Plain bytes decode only on a full window, the final byte drains it
    assign need_decode = last_reg ? status.nonempty : status.full;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            mqhd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.append = 1'b1;
                    last_next  = in_last;
                    state_next = mqhd_pkg::ST_DECODE;
                end
            end
            mqhd_pkg::ST_DECODE:
            begin
                if (need_decode)
                begin
                    if (status.out_free)
                    begin
                        cmd.decode = 1'b1;
                        // one decode always brings a plain window below full
                        if (!last_reg)
                            state_next = mqhd_pkg::ST_IDLE;
                    end
                end
                else if (last_reg)
                    state_next = mqhd_pkg::ST_CLOSE;
                else
                    state_next = mqhd_pkg::ST_IDLE;
            end
            mqhd_pkg::ST_CLOSE:
            begin
                if (status.out_free)
                begin
                    cmd.close  = 1'b1;
                    last_next  = 1'b0;
                    state_next = mqhd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mqhd_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_decode_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decode || cmd.close) |-> status.out_free)
        else $error("result produced while output register busy");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> state_reg == mqhd_pkg::ST_DECODE)
        else $error("accepted byte not followed by decode");

endmodule

[sv/mqhd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqhd_datapath
// Lookahead window, token match at the head, limit counter and output
// register.
// ----------------------------------------------------------------------------
module mqhd_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic [7:0]           in_byte,
    input  mqhd_pkg::dp_cmd_t    cmd,
    output mqhd_pkg::dp_status_t status,
    mqhd_out_if.source           out_ch
);

    localparam int DEPTH = mqhd_pkg::LOOKAHEAD_DEPTH;
    localparam int CW    = mqhd_pkg::CNT_W;

    logic [7:0]    la_reg [DEPTH];
    logic [7:0]    la_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          mode_reg;
    logic          mode_next;
    logic [15:0]   emitted_reg;
    logic [15:0]   emitted_next;
    logic          limit_reg;
    logic          limit_next;
    logic [15:0]   max_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic          byte_valid_reg;
    logic          byte_valid_next;
    logic          end_reg;
    logic          end_next;
    logic          trunc_reg;
    logic          trunc_next;

    logic          out_free;
    logic          match_start;
    logic          tok_ok;
    logic          q_end;
    logic          q_hex;
    logic          q_us;
    logic          emit_ok;
    logic [7:0]    head_byte;
    logic [CW-1:0] drop;

    assign out_free = !out_valid_reg || out_ch.ready;

    assign status.full     = count_reg == CW'(mqhd_pkg::START_LEN);
    assign status.nonempty = count_reg != '0;
    assign status.out_free = out_free;

    // Head classification
    always_comb
    begin
        tok_ok = 1'b1;
        for (int i = 0; i < mqhd_pkg::START_LEN; i++)
        begin
            if (mqhd_pkg::upcase(la_reg[i]) != mqhd_pkg::START_TOKEN[i])
                tok_ok = 1'b0;
        end
    end

    assign match_start = (count_reg >= CW'(mqhd_pkg::START_LEN)) && tok_ok;
    assign q_end = mode_reg && (count_reg >= CW'(2)) &&
                   la_reg[0] == mqhd_pkg::CH_QM && la_reg[1] == mqhd_pkg::CH_EQ;
    assign q_hex = mode_reg && (count_reg >= CW'(3)) && la_reg[0] == mqhd_pkg::CH_EQ &&
                   mqhd_pkg::is_hex(la_reg[1]) && mqhd_pkg::is_hex(la_reg[2]);
    assign q_us  = mode_reg && la_reg[0] == mqhd_pkg::CH_US;
    assign emit_ok = emitted_reg < max_reg;

    // Decoded byte and how far the window advances
    always_comb
    begin
        head_byte = la_reg[0];
        drop      = CW'(1);
        if (match_start)
            drop = CW'(mqhd_pkg::START_LEN);
        else if (q_end)
            drop = CW'(2);
        else if (q_hex)
        begin
            head_byte = {mqhd_pkg::hex_val(la_reg[1]), mqhd_pkg::hex_val(la_reg[2])};
            drop      = CW'(3);
        end
        else if (q_us)
            head_byte = mqhd_pkg::CH_SP;
    end

    // Window, mode, counters and output register
    always_comb
    begin
        la_next         = la_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        emitted_next    = emitted_reg;
        limit_next      = limit_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        end_next        = end_reg;
        trunc_next      = trunc_reg;

        if (cmd.append)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (count_reg == CW'(i))
                    la_next[i] = in_byte;
            end
            count_next = count_reg + CW'(1);
        end

        if (cmd.decode)
        begin
            // shift the window down by the consumed length
            for (int i = 0; i < DEPTH; i++)
            begin
                if (drop == CW'(1) && i + 1 < DEPTH)
                    la_next[i] = la_reg[i + 1];
                else if (drop == CW'(2) && i + 2 < DEPTH)
                    la_next[i] = la_reg[i + 2];
                else if (drop == CW'(3) && i + 3 < DEPTH)
                    la_next[i] = la_reg[i + 3];
            end
            count_next = count_reg - drop;
            if (match_start)
                mode_next = 1'b1;
            else if (q_end)
                mode_next = 1'b0;
            else if (emit_ok)
            begin
                emitted_next    = emitted_reg + 16'd1;
                out_valid_next  = 1'b1;
                out_byte_next   = head_byte;
                byte_valid_next = 1'b1;
                end_next        = 1'b0;
                trunc_next      = limit_reg;
            end
            else
                limit_next = 1'b1;
        end

        if (cmd.close)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = 8'd0;
            byte_valid_next = 1'b0;
            end_next        = 1'b1;
            trunc_next      = limit_reg;
            count_next      = '0;
            mode_next       = 1'b0;
            emitted_next    = 16'd0;
            limit_next      = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            emitted_reg   <= 16'd0;
            limit_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= mqhd_pkg::MAX_OUT_RESET;
        end
        else
        begin
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            emitted_reg   <= emitted_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                max_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        la_reg         <= la_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        end_reg        <= end_next;
        trunc_reg      <= trunc_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.byte_valid  = byte_valid_reg;
    assign out_ch.end_of_text = end_reg;
    assign out_ch.truncated   = trunc_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("lookahead count beyond window");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> count_reg == '0 && emitted_reg == 16'd0 && !limit_reg)
        else $error("text state not cleared after closing beat");

    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decode && out_valid_next && !out_valid_reg) |-> emit_ok)
        else $error("byte emitted past output limit");

endmodule

[sv/mime_q_header_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mime_q_header_decoder_core
// Q-encoded header word decoder: header text in, decoded bytes out.
// ----------------------------------------------------------------------------
// Bytes enter one per beat on in_ch and are held in a 15-byte lookahead
// window so the start token "=?ISO-8859-1?Q?" can be seen whole before the
// head byte is decided. A byte that is not final is stored, then a head
// decode runs if the window is full. The final byte is stored, then the
// window is drained by at most 15 head decodes, one decode per cycle
// through the single head-match unit, then the sequencer finds the window
// empty and sends the closing beat. Each decode or closing beat waits
// while the output register still holds an untaken beat. Decoded bytes
// past max_output_bytes (cfg_we/cfg_wdata, reset 65535) are dropped and
// flagged on truncated. Write the limit only while the block is idle.
// ----------------------------------------------------------------------------
module mime_q_header_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    mqhd_in_if.sink     in_ch,
    mqhd_out_if.source  out_ch
);

    mqhd_pkg::dp_cmd_t    cmd;
    mqhd_pkg::dp_status_t status;
    logic                 in_ready;

    assign in_ch.ready = in_ready;

    // Sequencer
    mqhd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.in_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Window and output datapath
    mqhd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_byte   (in_ch.in_byte),
        .cmd       (cmd),
        .status    (status),
        .out_ch    (out_ch)
    );

endmodule
